// ===== hw/rtl/qebd_pkg.sv =====
// Shared types, constants and the Gray transition table of the encoder decoder.
package qebd_pkg;

  localparam int unsigned PENDING_WIDTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF    = 32;

  localparam int unsigned CFG_DATA_WIDTH  = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned STEP_CFG_WIDTH  = 5;
  localparam int unsigned RESIDUE_WIDTH   = 5;
  localparam int unsigned NOW_WIDTH       = 32;
  localparam int unsigned DETENT_WIDTH    = 8;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_STEPS_PER_DETENT = 2'd0,
    CFG_LONG_HOLD_MS     = 2'd1,
    CFG_DEBOUNCE_MS      = 2'd2
  } cfg_index_t;

  localparam logic [STEP_CFG_WIDTH-1:0] STEPS_RESET     = 5'd4;
  localparam logic [STEP_CFG_WIDTH-1:0] STEPS_MIN       = 5'd1;
  localparam logic [STEP_CFG_WIDTH-1:0] STEPS_MAX       = 5'd16;
  localparam logic [15:0]               LONG_HOLD_RESET = 16'd800;
  localparam logic [15:0]               DEBOUNCE_RESET  = 16'd40;
  localparam logic [1:0]                PHASE_IDLE      = 2'b11;
  localparam int                        DETENT_CLAMP    = 127;

  // Step for a phase transition, indexed by {previous, current}; -1, 0 or +1.
  function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default:                 s = 2'sd0;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic                 mode;
    logic                 phase_a;
    logic                 phase_b;
    logic                 button_level;
    logic [NOW_WIDTH-1:0] now_ms;
    logic                 take_step;
    logic                 take_click;
    logic                 take_long;
  } req_t;

endpackage

// ===== hw/rtl/qebd_if.sv =====
// Request and result channel interfaces of the encoder decoder.
interface qebd_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        phase_a;
  logic        phase_b;
  logic        button_level;
  logic [31:0] now_ms;
  logic        take_step;
  logic        take_click;
  logic        take_long;

  modport source (output valid, mode, phase_a, phase_b, button_level, now_ms,
                  take_step, take_click, take_long, input ready);
  modport sink   (input valid, mode, phase_a, phase_b, button_level, now_ms,
                  take_step, take_click, take_long, output ready);
endinterface

interface qebd_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] detent_step;
  logic              click_event;
  logic              long_press_event;

  modport source (output valid, detent_step, click_event, long_press_event, input ready);
  modport sink   (input valid, detent_step, click_event, long_press_event, output ready);
endinterface

// ===== hw/rtl/quadrature_encoder_button_decoder_top.sv =====
// Top level of the quadrature encoder and push button decoder.
//
//   channel  direction  payload
//   req      sink       mode, phase_a, phase_b, button_level, now_ms, take_*
//   rsp      source     detent_step, click_event, long_press_event
//   cfg      write      cfg_we, cfg_index, cfg_data
//
// One request per cycle while the result channel is not stalled; each result passes through
// the input register and the result register. The rate is set by the state update between
// them. Synchronous reset returns the decoder state to the idle encoder and the configuration
// to its defaults. A stalled result holds; the input register still takes a request while the
// result register drains in the same cycle.
module quadrature_encoder_button_decoder_top #(
  parameter int unsigned PENDING_WIDTH = qebd_pkg::PENDING_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH    = qebd_pkg::TIME_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  qebd_req_if.sink                              req,
  qebd_rsp_if.source                            rsp,
  input  logic                                  cfg_we,
  input  logic [qebd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [qebd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  localparam logic signed [PENDING_WIDTH-1:0] PEND_MAX =
    PENDING_WIDTH'((64'sd1 <<< (PENDING_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PENDING_WIDTH-1:0] PEND_CLAMP =
    PENDING_WIDTH'(qebd_pkg::DETENT_CLAMP);

  // Configuration registers
  logic [qebd_pkg::STEP_CFG_WIDTH-1:0] steps_per_detent;
  logic [15:0]                         long_hold_ms;
  logic [15:0]                         debounce_ms;

  // Decoder state
  logic [1:0]                                prev_phase, prev_phase_next;
  logic signed [qebd_pkg::RESIDUE_WIDTH-1:0] detent_residue, detent_residue_next;
  logic signed [PENDING_WIDTH-1:0]           pending_steps, pending_steps_next;
  logic                                      last_button, last_button_next;
  logic                                      button_held, button_held_next;
  logic                                      long_sent, long_sent_next;
  logic [TIME_WIDTH-1:0]                     press_time, press_time_next;
  logic                                      click_pending, click_pending_next;
  logic                                      long_pending, long_pending_next;

  // Input register and result register
  qebd_pkg::req_t    s1;
  logic              s1_valid;
  logic              s1_adv;
  logic              out_valid;
  logic signed [7:0] detent_out, detent_next;
  logic              click_out, click_next;
  logic              long_out, long_next;

  // Working signals
  logic [qebd_pkg::STEP_CFG_WIDTH-1:0] k_eff;
  logic signed [1:0]                   step;
  logic signed [qebd_pkg::RESIDUE_WIDTH:0] res_sum, k_s;
  logic                                net_up, net_down;
  logic [TIME_WIDTH-1:0]               now_t, press_eff, hold_diff, dur;
  logic [TIME_WIDTH-1:0]               long_hold_t, debounce_t;
  logic                                press_edge, release_edge, held_eff, sent_eff;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  assign rsp.valid            = out_valid;
  assign rsp.detent_step      = detent_out;
  assign rsp.click_event      = click_out;
  assign rsp.long_press_event = long_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_detent <= qebd_pkg::STEPS_RESET;
      long_hold_ms     <= qebd_pkg::LONG_HOLD_RESET;
      debounce_ms      <= qebd_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qebd_pkg::CFG_STEPS_PER_DETENT:
          steps_per_detent <= cfg_data[qebd_pkg::STEP_CFG_WIDTH-1:0];
        qebd_pkg::CFG_LONG_HOLD_MS: long_hold_ms <= cfg_data;
        qebd_pkg::CFG_DEBOUNCE_MS:  debounce_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1.mode         <= req.mode;
      s1.phase_a      <= req.phase_a;
      s1.phase_b      <= req.phase_b;
      s1.button_level <= req.button_level;
      s1.now_ms       <= req.now_ms;
      s1.take_step    <= req.take_step;
      s1.take_click   <= req.take_click;
      s1.take_long    <= req.take_long;
    end
    if (s1_adv) begin
      detent_out <= detent_next;
      click_out  <= click_next;
      long_out   <= long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      prev_phase     <= qebd_pkg::PHASE_IDLE;
      detent_residue <= '0;
      pending_steps  <= '0;
      last_button    <= 1'b1;
      button_held    <= 1'b0;
      long_sent      <= 1'b0;
      press_time     <= '0;
      click_pending  <= 1'b0;
      long_pending   <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (s1_adv) begin
        prev_phase     <= prev_phase_next;
        detent_residue <= detent_residue_next;
        pending_steps  <= pending_steps_next;
        last_button    <= last_button_next;
        button_held    <= button_held_next;
        long_sent      <= long_sent_next;
        press_time     <= press_time_next;
        click_pending  <= click_pending_next;
        long_pending   <= long_pending_next;
      end
    end
  end

  always_comb begin
    prev_phase_next     = prev_phase;
    detent_residue_next = detent_residue;
    pending_steps_next  = pending_steps;
    last_button_next    = last_button;
    button_held_next    = button_held;
    long_sent_next      = long_sent;
    press_time_next     = press_time;
    click_pending_next  = click_pending;
    long_pending_next   = long_pending;
    detent_next         = '0;
    click_next          = 1'b0;
    long_next           = 1'b0;

    // Detent size is clamped into its legal range.
    if (steps_per_detent < qebd_pkg::STEPS_MIN) begin
      k_eff = qebd_pkg::STEPS_MIN;
    end else if (steps_per_detent > qebd_pkg::STEPS_MAX) begin
      k_eff = qebd_pkg::STEPS_MAX;
    end else begin
      k_eff = steps_per_detent;
    end
    k_s  = $signed({1'b0, k_eff});
    step = qebd_pkg::gray_step({prev_phase, s1.phase_a, s1.phase_b});
    res_sum = {detent_residue[qebd_pkg::RESIDUE_WIDTH-1], detent_residue}
            + {{(qebd_pkg::RESIDUE_WIDTH-1){step[1]}}, step};
    net_up   = res_sum >= k_s;
    net_down = !net_up && (res_sum <= -k_s);

    now_t        = s1.now_ms[TIME_WIDTH-1:0];
    long_hold_t  = TIME_WIDTH'(long_hold_ms);
    debounce_t   = TIME_WIDTH'(debounce_ms);
    press_edge   = !s1.button_level && last_button;
    release_edge = s1.button_level && !last_button;
    held_eff     = button_held || press_edge;
    sent_eff     = long_sent && !press_edge;
    press_eff    = press_edge ? now_t : press_time;
    hold_diff    = now_t - press_eff;
    dur          = (now_t >= press_time) ? (now_t - press_time) : '0;

    if (!s1.mode) begin
      prev_phase_next = {s1.phase_a, s1.phase_b};
      if (net_up) begin
        detent_residue_next = qebd_pkg::RESIDUE_WIDTH'(res_sum - k_s);
        if (pending_steps < PEND_MAX) begin
          pending_steps_next = pending_steps + PENDING_WIDTH'(1);
        end
      end else if (net_down) begin
        detent_residue_next = qebd_pkg::RESIDUE_WIDTH'(res_sum + k_s);
        if (pending_steps > -PEND_MAX) begin
          pending_steps_next = pending_steps - PENDING_WIDTH'(1);
        end
      end else begin
        detent_residue_next = qebd_pkg::RESIDUE_WIDTH'(res_sum);
      end

      button_held_next = held_eff;
      long_sent_next   = sent_eff;
      press_time_next  = press_eff;
      if (!s1.button_level && held_eff && !sent_eff && hold_diff >= long_hold_t) begin
        long_pending_next = 1'b1;
        long_sent_next    = 1'b1;
      end
      if (release_edge) begin
        // A release that follows a long press never gives a click.
        if (button_held && !long_sent && dur >= debounce_t && dur < long_hold_t) begin
          click_pending_next = 1'b1;
        end
        button_held_next = 1'b0;
        long_sent_next   = 1'b0;
      end
      last_button_next = s1.button_level;
    end else begin
      if (s1.take_step) begin
        if (pending_steps > PEND_CLAMP) begin
          detent_next = 8'sd127;
        end else if (pending_steps < -PEND_CLAMP) begin
          detent_next = -8'sd127;
        end else begin
          detent_next = pending_steps[qebd_pkg::DETENT_WIDTH-1:0];
        end
        pending_steps_next = '0;
      end
      if (s1.take_click) begin
        click_next         = click_pending;
        click_pending_next = 1'b0;
      end
      if (s1.take_long) begin
        long_next         = long_pending;
        long_pending_next = 1'b0;
      end
    end
  end

endmodule
